// ----- hdl/ffch_pkg.sv -----
// Package for the first-fit chunk heap allocator.
// Holds the transaction structs, opcode and status codes, header bit positions
// and the engine result struct. It depends on nothing.
package ffch_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OOM     = 2'd1;
	localparam logic [1:0] STATUS_DOUBLE  = 2'd2;
	localparam logic [1:0] STATUS_MISSING = 2'd3;

	localparam int HDR_W      = 18;
	localparam int HDR_EXISTS = 17;
	localparam int HDR_FREED  = 16;

	typedef struct packed {
		logic        opcode;
		logic [15:0] alloc_size;
		logic [15:0] user_offset;
	} req_t;

	typedef struct packed {
		logic [15:0] result_offset;
		logic [1:0]  status;
		logic [16:0] chunks_in_use;
		logic [16:0] chunks_freed;
	} rsp_t;

	typedef struct packed {
		logic [15:0] offset;
		logic [1:0]  status;
		logic        alloc_ok;
		logic        reuse;
		logic        free_ok;
	} eng_res_t;

endpackage

// ----- hdl/first_fit_chunk_heap_allocator_top.sv -----
// Top level of the first-fit chunk heap allocator.
// Depends on ffch_pkg and instantiates ffch_engine; holds the counts and the result register.
//
// After reset the header store is cleared one entry a cycle, all HEAP_BYTES entries of it,
// and no transaction is taken meanwhile. A free reads the header in front of its offset
// and then evaluates it. An allocate visits the chunk headers in turn, each with one memory
// read and one evaluation through the shared stride adder, so its time grows with the
// number of chunks in front of the one that fits. One request is worked on at a time; a
// finished result waits in an output register while the next request is taken.
module first_fit_chunk_heap_allocator_top #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffch_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffch_pkg::rsp_t rsp
);
	import ffch_pkg::*;

	logic        eng_idle;
	logic        res_valid;
	logic        res_take;
	eng_res_t    res;
	logic [16:0] in_use_q;
	logic [16:0] freed_q;
	logic [16:0] in_use_nxt;
	logic [16:0] freed_nxt;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	ffch_engine #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_valid && !req_stall),
		.item      (req),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign req_stall = !eng_idle;
	assign res_take  = !rsp_valid_q || !rsp_stall;

	assign in_use_nxt = in_use_q + {16'd0, res.alloc_ok} - {16'd0, res.free_ok};
	assign freed_nxt  = freed_q + {16'd0, res.free_ok} - {16'd0, res.reuse};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= '0;
			freed_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_take) begin
				in_use_q    <= in_use_nxt;
				freed_q     <= freed_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_q <= '{result_offset: res.offset, status: res.status,
				chunks_in_use: in_use_nxt, chunks_freed: freed_nxt};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/ffch_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the header store of the allocator; it depends on nothing.
module ffch_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// ----- hdl/ffch_engine.sv -----
// Sequencer of the allocator: clearing pass, header walk and free check.
// Depends on ffch_pkg and instantiates ffch_ram for the header store.
module ffch_engine #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ffch_pkg::req_t     item,
	output logic               idle,
	output logic               res_valid,
	input  logic               res_take,
	output ffch_pkg::eng_res_t res
);
	import ffch_pkg::*;

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int PW = ((AW > 17) ? AW : 17) + 1;
	localparam logic [PW-1:0] HEAP_P   = PW'(HEAP_BYTES);
	localparam logic [PW-1:0] HDR_P    = PW'(HEADER_BYTES);
	localparam logic [PW-1:0] LAST_POS = PW'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_BYTES - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_A_RD  = 3'd2;
	localparam logic [2:0] S_A_EV  = 3'd3;
	localparam logic [2:0] S_F_RD  = 3'd4;
	localparam logic [2:0] S_F_EV  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]       state_q;
	logic [AW-1:0]    clr_q;
	logic [PW-1:0]    pos_q;
	logic [15:0]      size_q;
	eng_res_t         res_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [HDR_W-1:0] wdata;
	logic [HDR_W-1:0] rdata;

	logic             h_exists;
	logic             h_freed;
	logic [15:0]      h_size;
	logic [15:0]      addend;
	logic [PW-1:0]    sum;
	logic [15:0]      pay_off;

	assign h_exists = rdata[HDR_EXISTS];
	assign h_freed  = rdata[HDR_FREED];
	assign h_size   = rdata[15:0];
	assign addend   = h_exists ? h_size : size_q;
	assign sum      = pos_q + HDR_P + {{(PW-16){1'b0}}, addend};
	assign pay_off  = 16'(pos_q + HDR_P);

	ffch_ram #(
		.WIDTH (HDR_W),
		.DEPTH (HEAP_BYTES)
	) u_hdr_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (pos_q[AW-1:0]),
		.rdata_q (rdata)
	);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[AW-1:0];
		wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			S_A_EV: begin
				if (h_exists && h_freed && h_size >= size_q) begin
					we    = 1'b1;
					wdata = {1'b1, 1'b0, h_size};
				end else if (!h_exists && sum <= HEAP_P) begin
					we    = 1'b1;
					wdata = {1'b1, 1'b0, size_q};
				end
			end
			S_F_EV: begin
				if (!h_freed && h_exists) begin
					we    = 1'b1;
					wdata = {1'b1, 1'b1, h_size};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= (item.opcode == OP_FREE) ? S_F_RD : S_A_RD;
					end
				end
				S_A_RD: begin
					state_q <= (pos_q > LAST_POS) ? S_DONE : S_A_EV;
				end
				S_A_EV: begin
					if ((h_exists && h_freed && h_size >= size_q) || !h_exists) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_F_RD: begin
					state_q <= (pos_q >= HEAP_P) ? S_DONE : S_F_EV;
				end
				S_F_EV: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				size_q <= item.alloc_size;
				res_q  <= '{offset: '0, status: STATUS_OK, alloc_ok: 1'b0,
					reuse: 1'b0, free_ok: 1'b0};
				if (item.opcode == OP_FREE) begin
					pos_q <= {{(PW-16){1'b0}}, item.user_offset} - HDR_P;
				end else begin
					pos_q <= '0;
				end
			end
			S_A_RD: begin
				if (pos_q > LAST_POS) begin
					res_q.status <= STATUS_OOM;
				end
			end
			S_A_EV: begin
				if (h_exists && h_freed && h_size >= size_q) begin
					res_q.offset   <= pay_off;
					res_q.alloc_ok <= 1'b1;
					res_q.reuse    <= 1'b1;
				end else if (!h_exists) begin
					if (sum > HEAP_P) begin
						res_q.status <= STATUS_OOM;
					end else begin
						res_q.offset   <= pay_off;
						res_q.alloc_ok <= 1'b1;
					end
				end else begin
					pos_q <= sum;
				end
			end
			S_F_RD: begin
				if (pos_q >= HEAP_P) begin
					res_q.status <= STATUS_MISSING;
				end
			end
			S_F_EV: begin
				if (h_freed) begin
					res_q.status <= STATUS_DOUBLE;
				end else if (!h_exists) begin
					res_q.status <= STATUS_MISSING;
				end else begin
					res_q.free_ok <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

// ----- tb/tb_first_fit_chunk_heap_allocator_top.sv -----
// Self-checking testbench for first_fit_chunk_heap_allocator_top.
// A scoreboard class keeps its own copy of the chunk headers and predicts every response.
// It depends on ffch_pkg and on the allocator RTL, and on nothing else.
module tb_first_fit_chunk_heap_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          HEAP_SIZE    = 65536;
	localparam int          HDR_BYTES    = 8;
	localparam int          RANDOM_ITEMS = 1850;
	localparam int          CHUNK_CAP    = 96;
	localparam int          TAIL_CYCLES  = 64;
	localparam int unsigned LIMIT_CYCLES = 3000000;

	class heap_scoreboard;
		logic [ffch_pkg::HDR_W-1:0] hdr_mem [HEAP_SIZE];
		logic [16:0]                live_cnt;
		logic [16:0]                freed_cnt;
		int unsigned                tail;
		int unsigned                chunk_cnt;
		int unsigned                live_offs [$];
		int unsigned                freed_offs [$];
		ffch_pkg::rsp_t             due_results [$];
		int                         errors;
		int                         checked;
		int                         allocs;
		int                         frees;
		int                         status_seen [4];

		function new();
			foreach (hdr_mem[i]) hdr_mem[i] = '0;
			live_cnt  = '0;
			freed_cnt = '0;
			tail      = 0;
			chunk_cnt = 0;
			errors    = 0;
			checked   = 0;
			allocs    = 0;
			frees     = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void shift_offset(int unsigned off, bit to_freed);
			if (to_freed) begin
				for (int i = 0; i < live_offs.size(); i++) begin
					if (live_offs[i] == off) begin
						live_offs.delete(i);
						break;
					end
				end
				freed_offs.push_back(off);
			end else begin
				for (int i = 0; i < freed_offs.size(); i++) begin
					if (freed_offs[i] == off) begin
						freed_offs.delete(i);
						break;
					end
				end
				live_offs.push_back(off);
			end
		endfunction

		function void place_chunk(input logic [15:0] size, output logic [15:0] offset,
				output logic [1:0] status);
			int unsigned                pos;
			logic [ffch_pkg::HDR_W-1:0] h;
			offset = '0;
			status = ffch_pkg::STATUS_OOM;
			pos    = 0;
			while (pos < HEAP_SIZE && HEAP_SIZE - pos >= HDR_BYTES) begin
				h = hdr_mem[pos];
				if (h[ffch_pkg::HDR_EXISTS] && h[ffch_pkg::HDR_FREED] && h[15:0] >= size) begin
					hdr_mem[pos][ffch_pkg::HDR_FREED] = 1'b0;
					freed_cnt = freed_cnt - 17'd1;
					live_cnt  = live_cnt + 17'd1;
					shift_offset(pos + HDR_BYTES, 1'b0);
					offset = 16'(pos + HDR_BYTES);
					status = ffch_pkg::STATUS_OK;
					return;
				end
				if (!h[ffch_pkg::HDR_EXISTS]) begin
					if (HEAP_SIZE - pos - HDR_BYTES >= size) begin
						hdr_mem[pos] = '0;
						hdr_mem[pos][ffch_pkg::HDR_EXISTS] = 1'b1;
						hdr_mem[pos][15:0] = size;
						live_cnt = live_cnt + 17'd1;
						live_offs.push_back(pos + HDR_BYTES);
						chunk_cnt++;
						tail   = pos + HDR_BYTES + size;
						offset = 16'(pos + HDR_BYTES);
						status = ffch_pkg::STATUS_OK;
					end
					return;
				end
				pos += HDR_BYTES + h[15:0];
			end
		endfunction

		function logic [1:0] mark_freed(logic [15:0] off);
			int unsigned                pos;
			logic [ffch_pkg::HDR_W-1:0] h;
			if (off < HDR_BYTES) return ffch_pkg::STATUS_MISSING;
			pos = off - HDR_BYTES;
			if (pos >= HEAP_SIZE) return ffch_pkg::STATUS_MISSING;
			h = hdr_mem[pos];
			if (h[ffch_pkg::HDR_FREED]) return ffch_pkg::STATUS_DOUBLE;
			if (!h[ffch_pkg::HDR_EXISTS]) return ffch_pkg::STATUS_MISSING;
			hdr_mem[pos][ffch_pkg::HDR_FREED] = 1'b1;
			freed_cnt = freed_cnt + 17'd1;
			live_cnt  = live_cnt - 17'd1;
			shift_offset(off, 1'b1);
			return ffch_pkg::STATUS_OK;
		endfunction

		function void take_request(ffch_pkg::req_t item);
			ffch_pkg::rsp_t want;
			logic [15:0]    offset;
			logic [1:0]     status;
			want = '0;
			if (item.opcode == ffch_pkg::OP_ALLOC) begin
				allocs++;
				place_chunk(item.alloc_size, offset, status);
				want.result_offset = offset;
				want.status        = status;
			end else begin
				frees++;
				want.status = mark_freed(item.user_offset);
			end
			want.chunks_in_use = live_cnt;
			want.chunks_freed  = freed_cnt;
			status_seen[want.status]++;
			due_results.push_back(want);
		endfunction

		function void compare_field(string field, logic [16:0] want, logic [16:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void match_result(ffch_pkg::rsp_t got);
			ffch_pkg::rsp_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: response with none expected, expected nothing, got %h",
					$time, got);
				return;
			end
			want = due_results.pop_front();
			checked++;
			compare_field("result_offset", 17'(want.result_offset), 17'(got.result_offset));
			compare_field("status", 17'(want.status), 17'(got.status));
			compare_field("chunks_in_use", want.chunks_in_use, got.chunks_in_use);
			compare_field("chunks_freed", want.chunks_freed, got.chunks_freed);
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	ffch_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	ffch_pkg::rsp_t rsp;

	heap_scoreboard sb;
	int unsigned    burst_left;
	int unsigned    cycle_cnt;
	bit             hold_done;

	first_fit_chunk_heap_allocator_top #(
		.HEAP_BYTES  (HEAP_SIZE),
		.HEADER_BYTES(HDR_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("%0t: run did not complete within %0d cycles", $time, LIMIT_CYCLES);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.match_result(rsp);
	end

	// The response side stalls in modes chosen at random for spans of random length, and once
	// holds off long enough for the allocator to back up into its request side.
	initial begin
		int unsigned mode;
		int unsigned span;
		rsp_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(32, 256);
			repeat (span) begin
				@(negedge clk);
				if (!hold_done && sb.checked >= 400) begin
					rsp_stall <= 1'b1;
					repeat (600) @(negedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0:       rsp_stall <= 1'b0;
					1:       rsp_stall <= ($urandom_range(0, 7) == 0);
					2:       rsp_stall <= 1'($urandom_range(0, 1));
					default: rsp_stall <= ($urandom_range(0, 15) < 12);
				endcase
			end
		end
	end

	function automatic ffch_pkg::req_t make_req(logic op, logic [15:0] size, logic [15:0] off);
		ffch_pkg::req_t item;
		item.opcode      = op;
		item.alloc_size  = (op == ffch_pkg::OP_ALLOC) ? size : 16'($urandom);
		item.user_offset = (op == ffch_pkg::OP_FREE) ? off : 16'($urandom);
		return item;
	endfunction

	// Mostly allocations paired with frees of live chunks; the chunk count is capped so
	// that the header walk stays short.
	function automatic ffch_pkg::req_t rand_request();
		int unsigned roll;
		int unsigned live_n;
		int unsigned freed_n;
		bit          want_alloc;
		logic [15:0] size;
		logic [15:0] off;
		live_n  = sb.live_offs.size();
		freed_n = sb.freed_offs.size();
		roll    = $urandom_range(0, 99);
		if (live_n < 4) want_alloc = (roll < 75);
		else if (live_n > 40) want_alloc = (roll < 30);
		else want_alloc = (roll < 52);
		if (want_alloc && sb.chunk_cnt >= CHUNK_CAP && freed_n == 0) want_alloc = 1'b0;
		roll = $urandom_range(0, 99);
		if (want_alloc) begin
			if (sb.chunk_cnt >= CHUNK_CAP) size = 16'd0;
			else if (roll < 65) size = 16'($urandom_range(0, 15));
			else if (roll < 93) size = 16'($urandom_range(16, 255));
			else size = 16'($urandom_range(HEAP_SIZE - sb.tail - HDR_BYTES + 1, 65535));
			return make_req(ffch_pkg::OP_ALLOC, size, '0);
		end
		if (roll < 70 && live_n != 0) off = 16'(sb.live_offs[$urandom_range(0, live_n - 1)]);
		else if (roll < 82 && freed_n != 0)
			off = 16'(sb.freed_offs[$urandom_range(0, freed_n - 1)]);
		else if (roll < 88) off = 16'($urandom_range(0, HDR_BYTES - 1));
		else if (roll < 94 && live_n != 0)
			off = 16'(sb.live_offs[$urandom_range(0, live_n - 1)] + $urandom_range(1, 3));
		else off = 16'($urandom);
		return make_req(ffch_pkg::OP_FREE, '0, off);
	endfunction

	task automatic offer(input ffch_pkg::req_t item);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
			case ($urandom_range(0, 3))
				0:       gap = 0;
				1:       gap = $urandom_range(1, 3);
				2:       gap = $urandom_range(4, 16);
				default: gap = $urandom_range(0, 40);
			endcase
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.take_request(item);
		@(negedge clk);
	endtask

	initial begin
		bit          variant;
		int unsigned fill_base;
		int unsigned fill;
		sb         = new();
		burst_left = 0;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd0));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'hFFFF));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'hFFFF, '0));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'd0, '0));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'd16, '0));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'd4, '0));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'd100, '0));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd7));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd20));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd16));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd16));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd52));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'd50, '0));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'd16, '0));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd8));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd8));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'd0, '0));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'd3, '0));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd160));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'd152));

		repeat (RANDOM_ITEMS) offer(rand_request());

		// Fill the heap to its end. One variant leaves a gap too small for a header; the
		// other ends on a zero-size chunk whose payload offset wraps to zero.
		variant = 1'($urandom_range(0, 1));
		if (variant) begin
			while (sb.freed_offs.size() != 0) offer(make_req(ffch_pkg::OP_ALLOC, 16'd0, '0));
		end
		fill_base = sb.tail;
		fill      = HEAP_SIZE - fill_base - HDR_BYTES - (variant ? HDR_BYTES : 3);
		offer(make_req(ffch_pkg::OP_ALLOC, 16'(fill), '0));
		offer(make_req(ffch_pkg::OP_FREE, '0, 16'(fill_base + HDR_BYTES)));
		offer(make_req(ffch_pkg::OP_ALLOC, 16'(fill), '0));
		if (variant) begin
			offer(make_req(ffch_pkg::OP_ALLOC, 16'd0, '0));
			offer(make_req(ffch_pkg::OP_ALLOC, 16'd0, '0));
		end
		offer(make_req(ffch_pkg::OP_ALLOC, 16'hFFFF, '0));
		req_valid <= 1'b0;

		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d transactions (%0d allocations, %0d frees) over %0d chunks.",
			sb.checked, sb.allocs, sb.frees, sb.chunk_cnt);
		$display("Statuses seen: ok %0d, out of memory %0d, double free %0d, missing %0d.",
			sb.status_seen[ffch_pkg::STATUS_OK], sb.status_seen[ffch_pkg::STATUS_OOM],
			sb.status_seen[ffch_pkg::STATUS_DOUBLE], sb.status_seen[ffch_pkg::STATUS_MISSING]);
		if (sb.errors == 0 && sb.due_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
